// ----- sv/bpfm_pkg.sv -----
// Package for the buffer pool frame manager: request codes, status codes,
// sequencer states. No dependencies.
package bpfm_pkg;

  localparam int DEF_POOL_FRAMES = 64;
  localparam int PAGE_W = 32;
  localparam int PIN_W = 16;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  localparam logic [2:0] REQ_FETCH = 3'd0;
  localparam logic [2:0] REQ_UNPIN = 3'd1;
  localparam logic [2:0] REQ_FLUSH = 3'd2;
  localparam logic [2:0] REQ_NEW = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFRAME = 2'd1;
  localparam logic [1:0] ST_NOTRES = 2'd2;
  localparam logic [1:0] ST_PINNED = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,    // fill the free FIFO after reset
    S_IDLE,
    S_LOOKUP,  // sweep frame table for the page
    S_HIT,     // pin count / dirty of the found frame available
    S_OBTAIN,  // read free FIFO head and LRU front
    S_PICK,    // choose free frame or LRU victim
    S_LRU,     // sweep LRU list, remove the frame and close the gap
    S_LOAD,    // load the new page into the frame
    S_OUT
  } state_t;

endpackage

// ----- sv/bpfm_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module bpfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/buffer_pool_frame_manager_core.sv -----
// Buffer pool frame manager, top level. Frame table, free FIFO and LRU list
// are kept in bpfm_ram instances; a sequencer walks them. Uses bpfm_pkg.
//
// Usage: a request enters on s_axis (req_type, page_id, new_page_id,
// dirty_mark). Exactly one result leaves on m_axis per request: status, frame,
// write-back order with page id, disk read order, deallocate order.
// One request is handled at a time: s_axis_tready is high only while idle.
// With F = POOL_FRAMES, the page lookup reads one frame entry per cycle.
// Taking a frame off the LRU list (fetch hit on an unpinned frame, delete,
// eviction) is one sweep of the list that also moves the later entries down.
// Unknown request codes go straight from idle to the output register.
// After reset the free FIFO is filled with frames 0 to F-1, one per cycle,
// and s_axis_tready stays low until the fill is done. Frame valid bits live
// in flip-flops and are cleared at once by reset.
// The result sits in an output register; while m_axis_tready is low it
// holds, and no new request is taken until it has gone.
module buffer_pool_frame_manager_core
  import bpfm_pkg::*;
#(
  parameter int POOL_FRAMES = DEF_POOL_FRAMES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[2:0], page_id[34:3], new_page_id[66:35], dirty_mark[67], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], frame_index[7:2], writeback_valid[8],
  // writeback_page_id[40:9], read_valid[41], dealloc_valid[42], zero pad
  output logic [47:0] m_axis_tdata
);

  localparam int AW = $clog2(POOL_FRAMES);
  localparam int CW = $clog2(POOL_FRAMES + 1);
  localparam logic [CW-1:0] NFR = CW'(POOL_FRAMES);
  localparam logic [AW-1:0] LASTF = AW'(POOL_FRAMES - 1);

  state_t state, state_next;

  // request
  logic [2:0]        req;
  logic [PAGE_W-1:0] pg, npg;
  logic              dm;

  // result
  logic [1:0]        r_status;
  logic [AW-1:0]     r_frame;
  logic              r_wb, r_rd, r_dl;
  logic [PAGE_W-1:0] r_wbpg;

  logic [POOL_FRAMES-1:0] fvalid;
  logic [AW-1:0]     free_head;
  logic [CW-1:0]     free_count, lru_count;
  logic [AW-1:0]     idx;       // sweep index
  logic              rd_ok;     // an entry read issued last cycle
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     fr;        // frame found / obtained
  logic              found;     // frame already met in the LRU sweep
  logic              evict;     // frame taken from the LRU front

  // memories
  logic              pg_we, pin_we, dt_we, ff_we, lr_we;
  logic [AW-1:0]     pg_wa, pg_ra, pin_wa, pin_ra, ff_wa, ff_ra, lr_wa, lr_ra;
  logic [PAGE_W-1:0] pg_wd, pg_rd;
  logic [PIN_W-1:0]  pin_wd, pin_rd;
  logic              dt_wd, dt_rd;
  logic [AW-1:0]     ff_wd, ff_rd, lr_wd, lr_rd;

  bpfm_ram #(.WIDTH(PAGE_W), .DEPTH(POOL_FRAMES)) u_page (
    .clk, .we(pg_we), .waddr(pg_wa), .wdata(pg_wd), .raddr(pg_ra), .rdata(pg_rd));
  bpfm_ram #(.WIDTH(PIN_W), .DEPTH(POOL_FRAMES)) u_pins (
    .clk, .we(pin_we), .waddr(pin_wa), .wdata(pin_wd), .raddr(pin_ra),
    .rdata(pin_rd));
  bpfm_ram #(.WIDTH(1), .DEPTH(POOL_FRAMES)) u_dirty (
    .clk, .we(dt_we), .waddr(pin_wa), .wdata(dt_wd), .raddr(pin_ra),
    .rdata(dt_rd));
  bpfm_ram #(.WIDTH(AW), .DEPTH(POOL_FRAMES)) u_free (
    .clk, .we(ff_we), .waddr(ff_wa), .wdata(ff_wd), .raddr(ff_ra), .rdata(ff_rd));
  bpfm_ram #(.WIDTH(AW), .DEPTH(POOL_FRAMES)) u_lru (
    .clk, .we(lr_we), .waddr(lr_wa), .wdata(lr_wd), .raddr(lr_ra), .rdata(lr_rd));

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] s;
    s = v - (AW+1)'(POOL_FRAMES);
    return (v >= (AW+1)'(POOL_FRAMES)) ? s[AW-1:0] : v[AW-1:0];
  endfunction

  logic hit, lk_last, lru_match, lru_done;
  assign hit = rd_ok && fvalid[rd_idx] && (pg_rd == pg);
  assign lk_last = rd_ok && (rd_idx == LASTF);
  assign lru_match = rd_ok && !found && (lr_rd == fr);
  assign lru_done = (lru_count == '0) ||
                    (rd_ok && (CW'(rd_idx) + CW'(1) >= lru_count));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (idx == LASTF) state_next = S_IDLE;
      S_IDLE: if (s_axis_tvalid) begin
        if (s_axis_tdata[2:0] == REQ_NEW) state_next = S_OBTAIN;
        else if (s_axis_tdata[2:0] inside {REQ_FETCH, REQ_UNPIN, REQ_FLUSH,
                                           REQ_DELETE})
          state_next = S_LOOKUP;
        else state_next = S_OUT;
      end
      S_LOOKUP: begin
        if (hit) state_next = S_HIT;
        else if (lk_last) state_next = (req == REQ_FETCH) ? S_OBTAIN : S_OUT;
      end
      S_HIT: begin
        // an unpinned frame sits in the LRU list and has to leave it
        if ((req == REQ_FETCH || req == REQ_DELETE) && pin_rd == '0)
          state_next = S_LRU;
        else state_next = S_OUT;
      end
      S_OBTAIN: state_next = S_PICK;
      S_PICK: begin
        if (free_count != '0) state_next = S_LOAD;
        else if (lru_count == '0) state_next = S_OUT;
        else state_next = S_LRU;
      end
      S_LRU: if (lru_done) state_next = evict ? S_LOAD : S_OUT;
      S_LOAD: state_next = S_OUT;
      S_OUT: if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    pg_we = 1'b0; pg_wa = fr; pg_wd = (req == REQ_NEW) ? npg : pg; pg_ra = fr;
    pin_we = 1'b0; dt_we = 1'b0; pin_wa = fr; pin_wd = PIN_W'(1); dt_wd = 1'b0;
    pin_ra = fr;
    ff_we = 1'b0; ff_wa = idx; ff_wd = idx; ff_ra = free_head;
    lr_we = 1'b0; lr_wa = rd_idx - AW'(1); lr_wd = lr_rd; lr_ra = idx;
    case (state)
      S_INIT: ff_we = 1'b1;
      S_LOOKUP: begin
        pg_ra = idx;
        pin_ra = rd_idx;
      end
      S_HIT: begin
        case (req)
          REQ_FETCH: begin
            pin_we = 1'b1;
            pin_wd = (pin_rd == PIN_MAX) ? pin_rd : pin_rd + PIN_W'(1);
          end
          REQ_UNPIN: begin
            pin_we = 1'b1; dt_we = 1'b1;
            pin_wd = (pin_rd != '0) ? pin_rd - PIN_W'(1) : pin_rd;
            dt_wd = dt_rd | dm;
            // pins reaching zero: append to the LRU tail
            if (pin_rd == PIN_W'(1) && lru_count < NFR) begin
              lr_we = 1'b1; lr_wa = lru_count[AW-1:0]; lr_wd = fr;
            end
          end
          REQ_FLUSH: begin
            dt_we = 1'b1; dt_wd = 1'b0;
          end
          REQ_DELETE: if (pin_rd == '0) begin
            dt_we = 1'b1; dt_wd = 1'b0;
            if (free_count < NFR) begin
              ff_we = 1'b1;
              ff_wa = wrap({1'b0, free_head} + (AW+1)'(free_count));
              ff_wd = fr;
            end
          end
          default: ;
        endcase
      end
      S_OBTAIN: lr_ra = '0;
      // entries after the removed one move down by one
      S_LRU: lr_we = rd_ok && found;
      S_LOAD: begin
        pg_we = 1'b1;
        pin_we = 1'b1; pin_wd = PIN_W'(1);
        dt_we = 1'b1; dt_wd = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      fvalid <= '0;
      free_head <= '0;
      free_count <= NFR;
      lru_count <= '0;
      idx <= '0;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT: idx <= idx + AW'(1);
        S_IDLE: if (s_axis_tvalid) begin
          req <= s_axis_tdata[2:0];
          pg <= s_axis_tdata[34:3];
          npg <= s_axis_tdata[66:35];
          dm <= s_axis_tdata[67];
          r_status <= ST_OK; r_frame <= '0; r_wb <= 1'b0; r_wbpg <= '0;
          r_rd <= 1'b0; r_dl <= 1'b0;
          idx <= '0; rd_ok <= 1'b0; rd_idx <= '0; evict <= 1'b0;
        end
        S_LOOKUP: begin
          rd_ok <= 1'b1; rd_idx <= idx;
          if (idx != LASTF) idx <= idx + AW'(1);
          if (hit) fr <= rd_idx;
          else if (lk_last && (req == REQ_UNPIN || req == REQ_FLUSH))
            r_status <= ST_NOTRES;
        end
        S_HIT: begin
          case (req)
            REQ_FETCH: r_frame <= fr;
            REQ_UNPIN: begin
              r_frame <= fr;
              if (pin_rd == PIN_W'(1) && lru_count < NFR)
                lru_count <= lru_count + CW'(1);
            end
            REQ_FLUSH: begin
              r_frame <= fr; r_wb <= 1'b1; r_wbpg <= pg;
            end
            REQ_DELETE: begin
              if (pin_rd != '0) r_status <= ST_PINNED;
              else begin
                fvalid[fr] <= 1'b0;
                r_dl <= 1'b1;
                if (free_count < NFR) free_count <= free_count + CW'(1);
              end
            end
            default: ;
          endcase
          idx <= '0; rd_ok <= 1'b0; found <= 1'b0;
        end
        S_PICK: begin
          if (free_count != '0) begin
            fr <= ff_rd;
            free_head <= wrap({1'b0, free_head} + (AW+1)'(1));
            free_count <= free_count - CW'(1);
          end else if (lru_count == '0) begin
            r_status <= ST_NOFRAME;
          end else begin
            fr <= lr_rd; evict <= 1'b1;
          end
          idx <= '0; rd_ok <= 1'b0; found <= 1'b0;
        end
        S_LRU: begin
          // page / dirty of fr are read throughout this sweep
          rd_ok <= 1'b1; rd_idx <= idx;
          if (idx != LASTF) idx <= idx + AW'(1);
          if (lru_match) found <= 1'b1;
          if (lru_done) begin
            if (found || lru_match) lru_count <= lru_count - CW'(1);
            if (evict && fvalid[fr] && dt_rd) begin
              r_wb <= 1'b1; r_wbpg <= pg_rd;
            end
          end
        end
        S_LOAD: begin
          fvalid[fr] <= 1'b1;
          r_frame <= fr;
          r_rd <= (req == REQ_FETCH);
        end
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {5'd0, r_dl, r_rd, r_wbpg, r_wb, 6'(r_frame), r_status};

endmodule
